// ===== sv/text_window_line_writer_macros.svh =====
// ---------------------------------------------------------------------------
// Text window line writer: assertion macros
// Shared property wrappers for the block's checker.
// ---------------------------------------------------------------------------
`ifndef TEXT_WINDOW_LINE_WRITER_MACROS_SVH
`define TEXT_WINDOW_LINE_WRITER_MACROS_SVH

// same-cycle implication
`define TWW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TWW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tww_pkg.sv =====
// ---------------------------------------------------------------------------
// Text window line writer package
// Result layout, step flags, character codes and action kinds.
// ---------------------------------------------------------------------------
`default_nettype none

package tww_pkg;

   // action kinds, carried on rsp_tuser
   localparam logic [1:0] KIND_SLOT   = 2'd0;
   localparam logic [1:0] KIND_SCROLL = 2'd1;
   localparam logic [1:0] KIND_FLUSH  = 2'd2;

   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_DIGIT0  = 8'd48;
   localparam logic [7:0] CHAR_DIGIT3  = 8'd51;

   localparam int TAB_STOP = 4;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] window_out;
      logic [4:0] column;
      logic [9:0] tile_value;
      logic [4:0] line_row;
      logic [5:0] line_count;
      logic       last;
   } result_type;

   typedef struct packed {
      logic col_full;       // line reached its column limit
      logic tab_more;       // tab still short of its stop
      logic next_row_full;  // updated row lies past the last row of the window
   } step_flags_type;

endpackage

`default_nettype wire

// ===== sv/tww_state_mem.sv =====
// ---------------------------------------------------------------------------
// Per-window state memory
// One word per window, registered read, valid bits so unwritten windows
// read as zero right after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module tww_state_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 15,
   parameter int IDX_W = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [WIDTH-1:0] rd_word_ff;
   logic             rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_word_ff  <= mem_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

// ===== sv/tww_step_unit.sv =====
// ---------------------------------------------------------------------------
// Step unit
// Shared column/row arithmetic: builds one result beat for a slot write,
// scroll or flush and the column and row that follow it.
// ---------------------------------------------------------------------------
`default_nettype none

module tww_step_unit #(
   parameter int LINE_COLUMNS = 32,
   parameter int WINDOW_ROWS  = 24
) (
   input  wire logic [1:0]                          op,
   input  wire logic [$clog2(LINE_COLUMNS+1)-1:0]   col,
   input  wire logic [$clog2(WINDOW_ROWS+1)-1:0]    row,
   input  wire logic [1:0]                          colour,
   input  wire logic [7:0]                          cur,
   input  wire logic                                pend,
   input  wire logic [3:0]                          window,
   output tww_pkg::result_type                      result,
   output logic      [$clog2(LINE_COLUMNS+1)-1:0]   col_next,
   output logic      [$clog2(WINDOW_ROWS+1)-1:0]    row_next,
   output tww_pkg::step_flags_type                  flags
);

   localparam int COL_W = $clog2(LINE_COLUMNS+1);
   localparam int ROW_W = $clog2(WINDOW_ROWS+1);

   logic       is_tab;
   logic [9:0] tile_sum;

   always_comb begin
      is_tab   = (cur == tww_pkg::CHAR_TAB);
      tile_sum = {1'b0, colour, 7'b0} + {2'b00, cur};

      result            = '0;
      result.window_out = window;
      col_next          = col;
      row_next          = row;

      case (op)
         tww_pkg::KIND_SLOT: begin
            result.kind       = tww_pkg::KIND_SLOT;
            result.column     = 5'(col);
            result.tile_value = is_tab ? 10'(tww_pkg::CHAR_SPACE) : tile_sum;
            col_next          = col + COL_W'(1);
         end
         tww_pkg::KIND_SCROLL: begin
            result.kind = tww_pkg::KIND_SCROLL;
            row_next    = ROW_W'(WINDOW_ROWS - 1);
         end
         tww_pkg::KIND_FLUSH: begin
            result.kind       = tww_pkg::KIND_FLUSH;
            result.line_row   = 5'(row);
            result.line_count = 6'(col);
            col_next          = '0;
            row_next          = row + ROW_W'(1);
         end
         default: begin
            result.kind = tww_pkg::KIND_SLOT;
         end
      endcase

      flags.col_full      = (col_next >= COL_W'(LINE_COLUMNS));
      flags.tab_more      = is_tab && !flags.col_full &&
                            ((col_next % COL_W'(tww_pkg::TAB_STOP)) != '0);
      flags.next_row_full = (row_next >= ROW_W'(WINDOW_ROWS));

      case (op)
         tww_pkg::KIND_SLOT:  result.last = !pend && !flags.tab_more && !flags.col_full;
         tww_pkg::KIND_FLUSH: result.last = !pend;
         default:             result.last = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/text_window_line_writer.sv =====
// ---------------------------------------------------------------------------
// Text window line writer
// Takes one character and a window number per beat and turns it into slot
// writes, scrolls and line flushes for that window. Per-window colour, row,
// column and escape state live in a small memory with a registered read;
// valid bits make every window read as zero after reset, so there is no
// clearing pass. A character goes through a state read and a decode, then
// one result beat per cycle from the shared step unit while the output is
// not stalled, then a write-back: an ordinary character gives one slot
// beat, a tab up to 4 slot beats, a line end one flush beat plus one scroll
// beat at the bottom row, at most 7 beats for one character. A window
// number at or above WINDOWS is taken and dropped in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module text_window_line_writer #(
   parameter int WINDOWS      = 16,
   parameter int LINE_COLUMNS = 32,
   parameter int WINDOW_ROWS  = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // char_code[7:0], window[11:8], zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // window_out[3:0], column[8:4],
                                         // tile_value[18:9], line_row[23:19],
                                         // line_count[29:24], zero
   output logic      [1:0]  rsp_tuser,   // kind
   output logic             rsp_tlast    // last
);

   localparam int COL_W  = $clog2(LINE_COLUMNS+1);
   localparam int ROW_W  = $clog2(WINDOW_ROWS+1);
   localparam int IDX_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
   localparam int WORD_W = 1 + 2 + ROW_W + COL_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SLOT   = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_FLUSH  = 3'd4;
   localparam logic [2:0] ST_WB     = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [7:0]          char_ff, char_in;
   logic [3:0]          win_ff, win_in;
   logic [7:0]          cur_ff, cur_in;
   logic                pend_ff, pend_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [1:0]          colour_ff, colour_in;
   logic                esc_ff, esc_in;
   tww_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [WORD_W-1:0]   rd_word;
   logic [WORD_W-1:0]   wr_word;
   logic                wr_en;
   logic [COL_W-1:0]    col0;
   logic [ROW_W-1:0]    row0;
   logic [1:0]          colour0;
   logic                esc0;

   logic [1:0]              u_op;
   logic [COL_W-1:0]        u_col;
   logic [ROW_W-1:0]        u_row;
   tww_pkg::result_type     u_result;
   logic [COL_W-1:0]        u_col_next;
   logic [ROW_W-1:0]        u_row_next;
   tww_pkg::step_flags_type u_flags;

   logic       emit_ok;
   logic       win_ok;
   logic       is_digit;

   // first state of a plain character: newline goes to the flush, via a scroll when the window is full
   function automatic logic [2:0] plain_start(input logic [7:0] ch,
                                              input logic row_full);
      logic [2:0] st;
      if (ch == tww_pkg::CHAR_NEWLINE) begin
         st = row_full ? ST_SCROLL : ST_FLUSH;
      end else begin
         st = ST_SLOT;
      end
      return st;
   endfunction

   assign col0    = rd_word[COL_W-1:0];
   assign row0    = rd_word[COL_W +: ROW_W];
   assign colour0 = rd_word[COL_W+ROW_W +: 2];
   assign esc0    = rd_word[WORD_W-1];
   assign wr_word = {esc_ff, colour_ff, row_ff, col_ff};

   tww_state_mem #(
      .DEPTH(WINDOWS),
      .WIDTH(WORD_W),
      .IDX_W(IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (IDX_W'(req_tdata[11:8])),
      .rd_data (rd_word),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(win_ff)),
      .wr_data (wr_word)
   );

   always_comb begin
      case (state_ff)
         ST_SCROLL: u_op = tww_pkg::KIND_SCROLL;
         ST_FLUSH:  u_op = tww_pkg::KIND_FLUSH;
         default:   u_op = tww_pkg::KIND_SLOT;
      endcase
      u_col = (state_ff == ST_DECODE) ? col0 : col_ff;
      u_row = (state_ff == ST_DECODE) ? row0 : row_ff;
   end

   tww_step_unit #(
      .LINE_COLUMNS(LINE_COLUMNS),
      .WINDOW_ROWS (WINDOW_ROWS)
   ) u_step (
      .op       (u_op),
      .col      (u_col),
      .row      (u_row),
      .colour   (colour_ff),
      .cur      (cur_ff),
      .pend     (pend_ff),
      .window   (win_ff),
      .result   (u_result),
      .col_next (u_col_next),
      .row_next (u_row_next),
      .flags    (u_flags)
   );

   assign emit_ok  = !rsp_valid_ff || rsp_tready;
   assign win_ok   = (7'(req_tdata[11:8]) < 7'(WINDOWS));
   assign is_digit = (char_ff >= tww_pkg::CHAR_DIGIT0) && (char_ff <= tww_pkg::CHAR_DIGIT3);

   always_comb begin
      state_in     = state_ff;
      char_in      = char_ff;
      win_in       = win_ff;
      cur_in       = cur_ff;
      pend_in      = pend_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      colour_in    = colour_ff;
      esc_in       = esc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               char_in = req_tdata[7:0];
               win_in  = req_tdata[11:8];
               if (win_ok) begin
                  state_in = ST_DECODE;
               end
            end
         end
         ST_DECODE: begin
            col_in    = col0;
            row_in    = row0;
            colour_in = colour0;
            esc_in    = esc0;
            pend_in   = 1'b0;
            if (esc0) begin
               if (is_digit) begin
                  colour_in = 2'(char_ff - tww_pkg::CHAR_DIGIT0);
                  esc_in    = 1'b0;
                  state_in  = ST_WB;
               end else begin
                  // literal percent first, then the character unless it opens a new escape
                  cur_in   = tww_pkg::CHAR_PERCENT;
                  pend_in  = (char_ff != tww_pkg::CHAR_PERCENT);
                  esc_in   = (char_ff == tww_pkg::CHAR_PERCENT);
                  state_in = plain_start(tww_pkg::CHAR_PERCENT, u_flags.next_row_full);
               end
            end else if (char_ff == tww_pkg::CHAR_PERCENT) begin
               esc_in   = 1'b1;
               state_in = ST_WB;
            end else begin
               cur_in   = char_ff;
               state_in = plain_start(char_ff, u_flags.next_row_full);
            end
         end
         ST_SLOT, ST_SCROLL, ST_FLUSH: begin
            if (emit_ok) begin
               rsp_in       = u_result;
               rsp_valid_in = 1'b1;
               col_in       = u_col_next;
               row_in       = u_row_next;
               if (state_ff == ST_SCROLL) begin
                  state_in = ST_FLUSH;
               end else if (state_ff == ST_SLOT && u_flags.tab_more) begin
                  state_in = ST_SLOT;
               end else if (state_ff == ST_SLOT && u_flags.col_full) begin
                  state_in = u_flags.next_row_full ? ST_SCROLL : ST_FLUSH;
               end else if (pend_ff) begin
                  cur_in   = char_ff;
                  pend_in  = 1'b0;
                  state_in = plain_start(char_ff, u_flags.next_row_full);
               end else begin
                  state_in = ST_WB;
               end
            end
         end
         ST_WB: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      win_ff    <= win_in;
      cur_ff    <= cur_in;
      pend_ff   <= pend_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      colour_ff <= colour_in;
      esc_ff    <= esc_in;
      rsp_ff    <= rsp_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.line_count, rsp_ff.line_row, rsp_ff.tile_value,
                        rsp_ff.column, rsp_ff.window_out};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

endmodule

`default_nettype wire

// ===== sv/tww_checker.sv =====
// ---------------------------------------------------------------------------
// Text window line writer checker
// Port-level properties of the line writer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "text_window_line_writer_macros.svh"

module tww_checker #(
   parameter int WINDOWS = 16
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   logic win_ok;
   logic is_slot;
   logic is_scroll;
   logic is_flush;

   assign win_ok    = (7'(req_tdata[11:8]) < 7'(WINDOWS));
   assign is_slot   = rsp_tvalid && (rsp_tuser == tww_pkg::KIND_SLOT);
   assign is_scroll = rsp_tvalid && (rsp_tuser == tww_pkg::KIND_SCROLL);
   assign is_flush  = rsp_tvalid && (rsp_tuser == tww_pkg::KIND_FLUSH);

   `TWW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp beat dropped while stalled")
   `TWW_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready && win_ok, !req_tready, "req taken again before character done")
   `TWW_ASSERT_NOW(a_scroll_not_last, clock, reset, is_scroll, !rsp_tlast, "scroll beat marked last")
   `TWW_ASSERT_NOW(a_slot_fields, clock, reset, is_slot, rsp_tdata[31:19] == 13'd0, "slot beat carries flush fields")
   `TWW_ASSERT_NOW(a_flush_fields, clock, reset, is_flush, rsp_tdata[18:4] == 15'd0, "flush beat carries slot fields")

endmodule

bind text_window_line_writer tww_checker #(.WINDOWS(WINDOWS)) u_tww_checker (.*);

`default_nettype wire

// ===== tb/text_window_line_writer_checker.sv =====
// ---------------------------------------------------------------------------
// Text window line writer checker
// Watches both streams of the line writer. Every accepted request beat is run
// through a per-window model of colour, row, column and escape state, and the
// slot writes, scrolls and flushes it should cause are queued in order. Every
// accepted response beat is compared field by field with the oldest queued
// beat. Failures are counted and handed to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_window_line_writer_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,   // char_code[7:0], window[11:8], zero
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // window_out[3:0], column[8:4],
                                         // tile_value[18:9], line_row[23:19],
                                         // line_count[29:24], zero
   input  wire logic [1:0]  rsp_tuser,   // kind
   input  wire logic        rsp_tlast,
   output int               fail_count,
   output int               beats_owed
);

   localparam int WINDOWS      = 16;
   localparam int LINE_COLUMNS = 32;
   localparam int WINDOW_ROWS  = 24;

   logic [1:0] win_colour [WINDOWS];
   logic [4:0] win_row    [WINDOWS];
   logic [5:0] win_column [WINDOWS];
   logic       win_escape [WINDOWS];

   tww_pkg::result_type expected_beats[$];
   tww_pkg::result_type char_beats[$];
   tww_pkg::result_type got_beat;
   tww_pkg::result_type want_beat;
   int                  fails = 0;

   function automatic string beat_text(tww_pkg::result_type b);
      return $sformatf("kind %0d win %0d col %0d tile %0d row %0d cnt %0d last %0d",
                       b.kind, b.window_out, b.column, b.tile_value, b.line_row,
                       b.line_count, b.last);
   endfunction

   task automatic push_beat(logic [1:0] kind, logic [3:0] w, logic [4:0] col,
                            logic [9:0] tile, logic [4:0] row, logic [5:0] cnt);
      tww_pkg::result_type b;
      b.kind       = kind;
      b.window_out = w;
      b.column     = col;
      b.tile_value = tile;
      b.line_row   = row;
      b.line_count = cnt;
      b.last       = 1'b0;
      char_beats.push_back(b);
   endtask

   task automatic put_tile(logic [3:0] w, logic [9:0] value);
      if (win_column[w] < LINE_COLUMNS) begin
         push_beat(tww_pkg::KIND_SLOT, w, win_column[w][4:0], value, 5'd0, 6'd0);
         win_column[w] = win_column[w] + 6'd1;
      end
   endtask

   // bottom row: scroll first, then the flush lands on the last row
   task automatic emit_line(logic [3:0] w);
      logic [4:0] row;
      row = win_row[w];
      if (row >= WINDOW_ROWS) begin
         push_beat(tww_pkg::KIND_SCROLL, w, 5'd0, 10'd0, 5'd0, 6'd0);
         row = 5'(WINDOW_ROWS - 1);
      end
      push_beat(tww_pkg::KIND_FLUSH, w, 5'd0, 10'd0, row, win_column[w]);
      win_column[w] = 6'd0;
      win_row[w]    = row + 5'd1;
   endtask

   task automatic plain_char(logic [3:0] w, logic [7:0] c);
      if (c == tww_pkg::CHAR_TAB) begin
         // a tab on a stop still moves one full stop
         if (win_column[w] % tww_pkg::TAB_STOP == 0 && win_column[w] < LINE_COLUMNS)
            put_tile(w, {2'b00, tww_pkg::CHAR_SPACE});
         while (win_column[w] % tww_pkg::TAB_STOP != 0 && win_column[w] < LINE_COLUMNS)
            put_tile(w, {2'b00, tww_pkg::CHAR_SPACE});
      end else if (c != tww_pkg::CHAR_NEWLINE) begin
         put_tile(w, {2'b00, c} + {1'b0, win_colour[w], 7'd0});
      end
      if (c == tww_pkg::CHAR_NEWLINE || win_column[w] >= LINE_COLUMNS)
         emit_line(w);
   endtask

   task automatic render_char(logic [7:0] c, logic [3:0] w);
      logic [7:0]          digit;
      tww_pkg::result_type b;
      char_beats.delete();
      if (win_escape[w]) begin
         if (c >= tww_pkg::CHAR_DIGIT0 && c <= tww_pkg::CHAR_DIGIT3) begin
            digit         = c - tww_pkg::CHAR_DIGIT0;
            win_colour[w] = digit[1:0];
            win_escape[w] = 1'b0;
         end else begin
            plain_char(w, tww_pkg::CHAR_PERCENT);
            if (c == tww_pkg::CHAR_PERCENT) begin
               win_escape[w] = 1'b1;
            end else begin
               win_escape[w] = 1'b0;
               plain_char(w, c);
            end
         end
      end else if (c == tww_pkg::CHAR_PERCENT) begin
         win_escape[w] = 1'b1;
      end else begin
         plain_char(w, c);
      end
      foreach (char_beats[i]) begin
         b      = char_beats[i];
         b.last = (i == char_beats.size() - 1);
         expected_beats.push_back(b);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOWS; i++) begin
            win_colour[i] = '0;
            win_row[i]    = '0;
            win_column[i] = '0;
            win_escape[i] = 1'b0;
         end
         expected_beats.delete();
      end else begin
         if (req_tvalid && req_tready)
            render_char(req_tdata[7:0], req_tdata[11:8]);
         if (rsp_tvalid && rsp_tready) begin
            got_beat.kind       = rsp_tuser;
            got_beat.window_out = rsp_tdata[3:0];
            got_beat.column     = rsp_tdata[8:4];
            got_beat.tile_value = rsp_tdata[18:9];
            got_beat.line_row   = rsp_tdata[23:19];
            got_beat.line_count = rsp_tdata[29:24];
            got_beat.last       = rsp_tlast;
            if (expected_beats.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("checker: beat with nothing expected: %s", beat_text(got_beat));
            end else begin
               want_beat = expected_beats.pop_front();
               if (got_beat !== want_beat) begin
                  fails++;
                  if (fails <= 10)
                     $display("checker: mismatch\n   expected %s\n   actual   %s",
                              beat_text(want_beat), beat_text(got_beat));
               end
            end
         end
      end
      fail_count <= fails;
      beats_owed <= expected_beats.size();
   end

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Text window line writer testbench
// Drives characters into the line writer: a directed run over colour escapes,
// literal percents, tabs, newlines and field extremes, then random text mixed
// over all windows and a newline-heavy run on one window to force scrolling.
// Both streams idle at random outside calm stretches; the checker does the
// prediction and this top gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          beats_owed;
   bit          calm = 1'b0;   // no idling on either side while set
   logic [3:0]  hot_window;

   text_window_line_writer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   text_window_line_writer_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .beats_owed (beats_owed)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("testbench: errors");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 35);
   end

   task automatic send_char(logic [7:0] c, logic [3:0] w);
      if (!calm && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, w, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // wait out queued beats, then the write-back of a beat-less character;
   // the count is registered, so it lags the last accept
   task automatic wait_drained();
      repeat (2) @(posedge clock);
      while (beats_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_text(int hot_pct, int newline_pct);
      logic [3:0] w;
      int         pick;
      w    = ($urandom_range(0, 99) < hot_pct) ? hot_window : 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < newline_pct) begin
         send_char(tww_pkg::CHAR_NEWLINE, w);
      end else if (pick < newline_pct + 8) begin
         send_char(tww_pkg::CHAR_TAB, w);
      end else if (pick < newline_pct + 16) begin
         send_char(tww_pkg::CHAR_PERCENT, w);
         send_char(8'($urandom_range(tww_pkg::CHAR_DIGIT0, tww_pkg::CHAR_DIGIT3)), w);
      end else if (pick < newline_pct + 20) begin
         send_char(tww_pkg::CHAR_PERCENT, w);
         send_char(8'($urandom_range(8'h20, 8'h7E)), w);
      end else if (pick < newline_pct + 23) begin
         send_char(tww_pkg::CHAR_PERCENT, w);
         send_char(tww_pkg::CHAR_PERCENT, w);
      end else if (pick < newline_pct + 35) begin
         send_char(8'($urandom_range(0, 255)), w);
      end else begin
         send_char(8'($urandom_range(8'h20, 8'h7E)), w);
      end
   endtask

   initial begin
      hot_window = 4'($urandom_range(0, 15));
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, escapes, tabs, line ends
      send_char(8'h00, 4'd0);              // null goes out as a tile
      send_char(8'hFF, 4'd15);
      send_char(8'h41, 4'd0);
      send_char(tww_pkg::CHAR_PERCENT, 4'd0);
      send_char(tww_pkg::CHAR_DIGIT3, 4'd0);   // colour 3
      send_char(8'hFF, 4'd0);              // largest tile value
      send_char(tww_pkg::CHAR_PERCENT, 4'd0);
      send_char(tww_pkg::CHAR_DIGIT0, 4'd0);
      send_char(tww_pkg::CHAR_TAB, 4'd0);      // off a stop
      send_char(tww_pkg::CHAR_TAB, 4'd0);      // on a stop
      send_char(tww_pkg::CHAR_PERCENT, 4'd15);
      send_char(8'h78, 4'd15);             // literal percent, then the char
      send_char(tww_pkg::CHAR_PERCENT, 4'd15);
      send_char(tww_pkg::CHAR_PERCENT, 4'd15); // literal percent, new escape
      send_char(8'd49, 4'd15);
      send_char(8'h42, 4'd15);
      send_char(tww_pkg::CHAR_NEWLINE, 4'd0);
      send_char(tww_pkg::CHAR_NEWLINE, 4'd15);
      send_char(tww_pkg::CHAR_NEWLINE, 4'd3);  // empty line
      send_char(tww_pkg::CHAR_PERCENT, 4'd1);
      send_char(tww_pkg::CHAR_NEWLINE, 4'd1);
      send_char(tww_pkg::CHAR_PERCENT, 4'd2);
      send_char(tww_pkg::CHAR_TAB, 4'd2);
      req_tvalid <= 1'b0;
      wait_drained();

      // mixed text over all windows
      repeat (25) random_text(60, 12);

      // newline-heavy run on one window so its rows reach the bottom
      calm = 1'b1;
      repeat (25) random_text(90, 60);
      calm = 1'b0;
      repeat (25) random_text(90, 60);

      // leave an escape open at the end of the stream
      send_char(tww_pkg::CHAR_NEWLINE, 4'd9);
      send_char(tww_pkg::CHAR_PERCENT, 4'd9);
      req_tvalid <= 1'b0;
      wait_drained();

      if (fail_count == 0 && beats_owed == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
